[rtl/gpg_pkg.sv]
// shared types, constants and register codes of the gradient palette generator
package gpg_pkg;

	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;
	localparam int CH_W    = 6;
	localparam int NUM_CH  = 3;
	localparam int COLOR_W = NUM_CH * CH_W;
	localparam int IDX_W   = 8;
	localparam int WT_W    = 9;
	localparam int SUM_W   = 14;
	localparam int RECIP_W = 10;
	localparam int RECIP_SH = 16;
	localparam int Q_W     = 7;
	localparam int DIV_W   = 8;
	localparam int PROD_W  = SUM_W + RECIP_W;
	localparam int REM_W   = Q_W + DIV_W;

	// register indexes
	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_START  = 2'd1;
	localparam logic [1:0] REG_MIDDLE = 2'd2;
	localparam logic [1:0] REG_FINISH = 2'd3;

	// ramp modes
	localparam logic [1:0] MODE_SINGLE = 2'd0;
	localparam logic [1:0] MODE_MIRROR = 2'd1;
	localparam logic [1:0] MODE_CYCLE  = 2'd2;

	localparam logic [COLOR_W-1:0] START_RESET  = '0;
	localparam logic [COLOR_W-1:0] MIDDLE_RESET = '0;
	localparam logic [COLOR_W-1:0] FINISH_RESET = '1;

	// divisor selection
	typedef logic [1:0] div_sel_t;
	localparam div_sel_t DIV_255 = 2'd0;
	localparam div_sel_t DIV_128 = 2'd1;
	localparam div_sel_t DIV_85  = 2'd2;

	// index [2] red, [1] green, [0] blue, matching the packed register layout
	typedef logic [NUM_CH-1:0][CH_W-1:0] rgb_t;

	typedef struct packed {
		logic [1:0] mode;
		rgb_t       start;
		rgb_t       middle;
		rgb_t       finish;
	} cfg_t;

	typedef struct packed {
		logic [WT_W-1:0] wa;
		logic [WT_W-1:0] wb;
		rgb_t            a;
		rgb_t            b;
		div_sel_t        div;
	} blend_req_t;

	typedef struct packed {
		logic [NUM_CH-1:0][SUM_W-1:0] sum;
		div_sel_t                     div;
	} blend_sum_t;

	// reciprocal scaled by 2^16, rounded down so the estimate never overshoots
	function automatic logic [RECIP_W-1:0] recip_of(div_sel_t d);
		logic [RECIP_W-1:0] r;
		begin
			case (d)
				DIV_128: r = 10'd512;
				DIV_85:  r = 10'd771;
				default: r = 10'd257;
			endcase
			return r;
		end
	endfunction

	function automatic logic [DIV_W-1:0] divisor_of(div_sel_t d);
		logic [DIV_W-1:0] v;
		begin
			case (d)
				DIV_128: v = 8'd128;
				DIV_85:  v = 8'd85;
				default: v = 8'd255;
			endcase
			return v;
		end
	endfunction

endpackage

[rtl/gradient_palette_generator.sv]
// top level of the gradient palette generator
//
//   channel  | handshake          | payload
//   ---------+--------------------+--------------------------------
//   input    | in_valid, in_stall | entry_index
//   output   | out_valid, out_stall | red, green, blue
//   config   | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// one item per cycle sustained while out_stall stays low
// stages: weight decode, weighted sum, reciprocal multiply, remainder correction
// arst_n clears all valid bits and loads the register reset values
// a stall holds each full stage up to the first empty one; empty stages keep filling, nothing is dropped
module gradient_palette_generator
	import gpg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [IDX_W-1:0]  entry_index,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [CH_W-1:0]   red,
	output logic [CH_W-1:0]   green,
	output logic [CH_W-1:0]   blue
);

	cfg_t       cfg;
	logic       valid_s1;
	logic       stall_s1;
	blend_req_t req_s1;
	logic       valid_s2;
	logic       stall_s2;
	blend_sum_t sum_s2;
	rgb_t       level;

	gpg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	gpg_weight u_weight (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.entry_index (entry_index),
		.valid_s1    (valid_s1),
		.stall_s1    (stall_s1),
		.req_s1      (req_s1)
	);

	gpg_blend u_blend (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.stall_s1 (stall_s1),
		.req_s1   (req_s1),
		.valid_s2 (valid_s2),
		.stall_s2 (stall_s2),
		.sum_s2   (sum_s2)
	);

	gpg_divide u_divide (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s2  (valid_s2),
		.stall_s2  (stall_s2),
		.sum_s2    (sum_s2),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.level     (level)
	);

	assign red   = level[2];
	assign green = level[1];
	assign blue  = level[0];

endmodule

[rtl/gpg_regs.sv]
// configuration registers behind the apb-style port
module gpg_regs
	import gpg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [1:0]         mode_q;
	logic [COLOR_W-1:0] start_q;
	logic [COLOR_W-1:0] middle_q;
	logic [COLOR_W-1:0] finish_q;
	logic               wr_en;
	logic [1:0]         reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_SINGLE;
			start_q  <= START_RESET;
			middle_q <= MIDDLE_RESET;
			finish_q <= FINISH_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_MODE:   mode_q   <= pwdata[1:0];
				REG_START:  start_q  <= pwdata[COLOR_W-1:0];
				REG_MIDDLE: middle_q <= pwdata[COLOR_W-1:0];
				REG_FINISH: finish_q <= pwdata[COLOR_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MODE:   prdata = {{(DATA_W-2){1'b0}}, mode_q};
			REG_START:  prdata = {{(DATA_W-COLOR_W){1'b0}}, start_q};
			REG_MIDDLE: prdata = {{(DATA_W-COLOR_W){1'b0}}, middle_q};
			REG_FINISH: prdata = {{(DATA_W-COLOR_W){1'b0}}, finish_q};
		endcase
	end

	assign cfg.mode   = mode_q;
	assign cfg.start  = rgb_t'(start_q);
	assign cfg.middle = rgb_t'(middle_q);
	assign cfg.finish = rgb_t'(finish_q);

endmodule

[rtl/gpg_weight.sv]
// stage 1: segment decode, blend weights and endpoint colors
module gpg_weight
	import gpg_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [IDX_W-1:0] entry_index,
	output logic             valid_s1,
	input  logic             stall_s1,
	output blend_req_t       req_s1
);

	blend_req_t      req;
	logic [WT_W-1:0] idx;
	logic [WT_W-1:0] k_mirror;
	logic [WT_W-1:0] k_mid;
	logic [WT_W-1:0] k_last;

	assign idx      = {1'b0, entry_index};
	assign k_mirror = idx - 9'd127;
	assign k_mid    = idx - 9'd85;
	assign k_last   = idx - 9'd170;

	always_comb begin
		req.wa  = idx;
		req.wb  = 9'd256 - idx;
		req.a   = cfg.start;
		req.b   = cfg.finish;
		req.div = DIV_255;
		case (cfg.mode)
			MODE_MIRROR: begin
				req.div = DIV_128;
				if (idx <= 9'd128) begin
					req.wa = idx;
					req.wb = 9'd128 - idx;
					req.a  = cfg.finish;
					req.b  = cfg.start;
				end else begin
					req.wa = k_mirror;
					req.wb = 9'd128 - k_mirror;
					req.a  = cfg.start;
					req.b  = cfg.finish;
				end
			end
			MODE_CYCLE: begin
				req.div = DIV_85;
				if (idx <= 9'd85) begin
					req.wa = idx;
					req.wb = 9'd86 - idx;
					req.a  = cfg.middle;
					req.b  = cfg.start;
				end else if (idx <= 9'd170) begin
					req.wa = k_mid;
					req.wb = 9'd86 - k_mid;
					req.a  = cfg.finish;
					req.b  = cfg.middle;
				end else begin
					req.wa = k_last;
					req.wb = 9'd86 - k_last;
					req.a  = cfg.start;
					req.b  = cfg.finish;
				end
			end
			default: ;
		endcase
		// entry zero is black
		if (entry_index == '0) begin
			req.wa = '0;
			req.wb = '0;
		end
	end

	assign in_stall = valid_s1 & stall_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			req_s1 <= req;
		end
	end

endmodule

[rtl/gpg_blend.sv]
// stage 2: weighted sum of the two endpoint levels per channel
module gpg_blend
	import gpg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid_s1,
	output logic       stall_s1,
	input  blend_req_t req_s1,
	output logic       valid_s2,
	input  logic       stall_s2,
	output blend_sum_t sum_s2
);

	blend_sum_t                          sum;
	logic [NUM_CH-1:0][WT_W+CH_W-1:0]    prod_a;
	logic [NUM_CH-1:0][WT_W+CH_W-1:0]    prod_b;
	logic [NUM_CH-1:0][WT_W+CH_W:0]      total;

	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			prod_a[ch]  = {{CH_W{1'b0}}, req_s1.wa} * {{WT_W{1'b0}}, req_s1.a[ch]};
			prod_b[ch]  = {{CH_W{1'b0}}, req_s1.wb} * {{WT_W{1'b0}}, req_s1.b[ch]};
			total[ch]   = {1'b0, prod_a[ch]} + {1'b0, prod_b[ch]};
			sum.sum[ch] = total[ch][SUM_W-1:0];
		end
		sum.div = req_s1.div;
	end

	assign stall_s1 = valid_s2 & stall_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!stall_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall_s1 && valid_s1) begin
			sum_s2 <= sum;
		end
	end

endmodule

[rtl/gpg_divide.sv]
// stages 3 and 4: reciprocal multiply, then remainder correction into the output register
module gpg_divide
	import gpg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid_s2,
	output logic       stall_s2,
	input  blend_sum_t sum_s2,
	output logic       out_valid,
	input  logic       out_stall,
	output rgb_t       level
);

	logic [NUM_CH-1:0][PROD_W-1:0] prod;
	logic [RECIP_W-1:0]            recip;
	logic                          valid_s3;
	logic                          stall_s3;
	blend_sum_t                    sum_s3;
	logic [NUM_CH-1:0][Q_W-1:0]    q_s3;
	logic [DIV_W-1:0]              divisor;
	logic [NUM_CH-1:0][REM_W-1:0]  rem;
	logic [NUM_CH-1:0][Q_W-1:0]    q_fix;
	rgb_t                          level_fix;
	logic                          valid_s4;
	rgb_t                          level_s4;

	assign recip = recip_of(sum_s2.div);

	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			prod[ch] = {{RECIP_W{1'b0}}, sum_s2.sum[ch]} * {{SUM_W{1'b0}}, recip};
		end
	end

	assign stall_s3 = valid_s4 & out_stall;
	assign stall_s2 = valid_s3 & stall_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (!stall_s2) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall_s2 && valid_s2) begin
			sum_s3 <= sum_s2;
			for (int ch = 0; ch < NUM_CH; ch++) begin
				q_s3[ch] <= prod[ch][RECIP_SH +: Q_W];
			end
		end
	end

	// the estimate is the quotient or one below it
	assign divisor = divisor_of(sum_s3.div);

	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			rem[ch] = {{(REM_W-SUM_W){1'b0}}, sum_s3.sum[ch]}
				- ({{DIV_W{1'b0}}, q_s3[ch]} * {{Q_W{1'b0}}, divisor});
			if (rem[ch] >= {{Q_W{1'b0}}, divisor}) begin
				q_fix[ch] = q_s3[ch] + 7'd1;
			end else begin
				q_fix[ch] = q_s3[ch];
			end
			level_fix[ch] = q_fix[ch][CH_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (!stall_s3) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall_s3 && valid_s3) begin
			level_s4 <= level_fix;
		end
	end

	assign out_valid = valid_s4;
	assign level     = level_s4;

endmodule

[sim/tb_top.sv]
// testbench for the gradient palette generator: directed and random streams of entry indexes against a predictor
module tb_top
	import gpg_pkg::*;
();

	localparam logic [1:0]         MODE_UNUSED = 2'd3;
	localparam logic [COLOR_W-1:0] COLOR_WHITE = '1;
	localparam logic [COLOR_W-1:0] COLOR_BLACK = '0;
	localparam int                 CYCLE_LIMIT = 200000;
	localparam int                 PHASES      = 8;
	localparam int                 PHASE_ITEMS = 100;

	class palette_scoreboard;
		logic [1:0] mode;
		rgb_t       start_c;
		rgb_t       middle_c;
		rgb_t       finish_c;
		rgb_t       expected_colors[$];
		int         mismatch_count;

		function new();
			mode = MODE_SINGLE;
			start_c = START_RESET;
			middle_c = MIDDLE_RESET;
			finish_c = FINISH_RESET;
			mismatch_count = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [DATA_W-1:0] word);
			case (idx)
				REG_MODE:   mode = word[1:0];
				REG_START:  start_c = rgb_t'(word[COLOR_W-1:0]);
				REG_MIDDLE: middle_c = rgb_t'(word[COLOR_W-1:0]);
				REG_FINISH: finish_c = rgb_t'(word[COLOR_W-1:0]);
				default: ;
			endcase
		endfunction

		function logic [CH_W-1:0] ramp_level(logic [IDX_W-1:0] idx, logic [CH_W-1:0] s,
				logic [CH_W-1:0] m, logic [CH_W-1:0] f);
			int unsigned i, wt, hi, lo, span, div;
			i = idx;
			if (i == 0)
				return '0;
			case (mode)
				MODE_MIRROR: begin
					span = 128;
					div = 128;
					if (i <= 128) begin
						wt = i; hi = f; lo = s;
					end else begin
						wt = i - 127; hi = s; lo = f;
					end
				end
				MODE_CYCLE: begin
					span = 86;
					div = 85;
					if (i <= 85) begin
						wt = i; hi = m; lo = s;
					end else if (i <= 170) begin
						wt = i - 85; hi = f; lo = m;
					end else begin
						wt = i - 170; hi = s; lo = f;
					end
				end
				default: begin
					span = 256; div = 255; wt = i; hi = s; lo = f;
				end
			endcase
			return CH_W'((wt * hi + (span - wt) * lo) / div);
		endfunction

		function void note_index(logic [IDX_W-1:0] idx);
			rgb_t c;
			for (int ch = 0; ch < NUM_CH; ch++)
				c[ch] = ramp_level(idx, start_c[ch], middle_c[ch], finish_c[ch]);
			expected_colors.push_back(c);
		endfunction

		function void check_color(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b);
			rgb_t c;
			if (expected_colors.size() == 0) begin
				$error("unexpected color: red %0d green %0d blue %0d", r, g, b);
				mismatch_count++;
				return;
			end
			c = expected_colors.pop_front();
			if (r !== c[2]) begin
				$error("red mismatch: expected %0d, got %0d", c[2], r);
				mismatch_count++;
			end
			if (g !== c[1]) begin
				$error("green mismatch: expected %0d, got %0d", c[1], g);
				mismatch_count++;
			end
			if (b !== c[0]) begin
				$error("blue mismatch: expected %0d, got %0d", c[0], b);
				mismatch_count++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [IDX_W-1:0]  entry_index = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [CH_W-1:0]   red;
	logic [CH_W-1:0]   green;
	logic [CH_W-1:0]   blue;

	palette_scoreboard sb;
	int                cycle_count = 0;
	int                burst_left = 0;
	int                stall_left = 0;
	int                stall_pct = 0;

	gradient_palette_generator uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.entry_index(entry_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.red(red),
		.green(green),
		.blue(blue)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_left <= $urandom_range(16, 160);
			case ($urandom_range(0, 3))
				0: stall_pct <= 0;
				1: stall_pct <= 20;
				2: stall_pct <= 50;
				default: stall_pct <= 85;
			endcase
		end else begin
			stall_left <= stall_left - 1;
		end
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_index(entry_index);
		if (arst_n && out_valid && !out_stall)
			sb.check_color(red, green, blue);
	end

	task automatic send_index(input logic [IDX_W-1:0] idx);
		int gap;
		in_valid <= 1'b1;
		entry_index <= idx;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_set(input logic [IDX_W-1:0] idx_q[$]);
		foreach (idx_q[k])
			send_index(idx_q[k]);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.expected_colors.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [COLOR_W-1:0] value);
		logic [DATA_W-1:0] word;
		word = $urandom;
		if (idx == REG_MODE)
			word[1:0] = value[1:0];
		else
			word[COLOR_W-1:0] = value;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sb.set_reg(idx, word);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic logic [COLOR_W-1:0] pick_color();
		rgb_t c;
		case ($urandom_range(0, 5))
			0: c = COLOR_BLACK;
			1: c = COLOR_WHITE;
			2: for (int ch = 0; ch < NUM_CH; ch++)
				c[ch] = $urandom_range(0, 1) ? '1 : '0;
			default: c = rgb_t'($urandom);
		endcase
		return c;
	endfunction

	function automatic logic [IDX_W-1:0] pick_index();
		logic [IDX_W-1:0] edges[10] = '{0, 1, 85, 86, 127, 128, 129, 170, 171, 255};
		if ($urandom_range(0, 7) == 0)
			return edges[$urandom_range(0, 9)];
		return IDX_W'($urandom_range(0, 255));
	endfunction

	initial begin
		logic [IDX_W-1:0] idx_q[$];
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset colors, single ramp
		idx_q = '{8'd0, 8'd1, 8'd128, 8'd255};
		send_set(idx_q);
		drain();

		write_reg(REG_MODE, COLOR_W'(MODE_MIRROR));
		write_reg(REG_START, COLOR_WHITE);
		write_reg(REG_FINISH, COLOR_BLACK);
		idx_q = '{8'd0, 8'd127, 8'd128, 8'd129, 8'd255};
		send_set(idx_q);
		drain();

		write_reg(REG_MODE, COLOR_W'(MODE_CYCLE));
		write_reg(REG_MIDDLE, 18'h00FC0);
		write_reg(REG_FINISH, 18'h2A95A);
		idx_q = '{8'd0, 8'd85, 8'd86, 8'd170, 8'd171, 8'd255};
		send_set(idx_q);
		drain();

		// unused mode falls back to the single ramp
		write_reg(REG_MODE, COLOR_W'(MODE_UNUSED));
		idx_q = '{8'd0, 8'd1, 8'd255};
		send_set(idx_q);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			write_reg(REG_MODE, COLOR_W'($urandom_range(0, 3)));
			if (p == 0 || $urandom_range(0, 3) != 0)
				write_reg(REG_START, pick_color());
			if (p == 0 || $urandom_range(0, 3) != 0)
				write_reg(REG_MIDDLE, pick_color());
			if (p == 0 || $urandom_range(0, 3) != 0)
				write_reg(REG_FINISH, pick_color());
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_index(pick_index());
			drain();
		end

		if (sb.mismatch_count == 0 && sb.expected_colors.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[filelist.f]
rtl/gpg_pkg.sv
rtl/gpg_regs.sv
rtl/gpg_weight.sv
rtl/gpg_blend.sv
rtl/gpg_divide.sv
rtl/gradient_palette_generator.sv
sim/tb_top.sv
